>>> rtl/core/efra_pkg.sv
package efra_pkg;

    localparam int IN_TIME_W = 40;
    localparam int TIME_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int ROOM_W    = 4;
    localparam int CFG_W     = 5;

    localparam int S_DATA_W  = 2 * IN_TIME_W;
    localparam int M_DATA_W  = ROOM_W + TIME_W + ROOM_W + COUNT_W;

    localparam logic [CFG_W-1:0]   CFG_RESET  = CFG_W'(16);
    localparam logic [TIME_W-1:0]  TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

>>> rtl/core/efra_ram.sv
module efra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/earliest_free_room_allocator.sv
// Earliest-free room allocator. Each booking word (start, end) goes to the lowest-numbered
// room that is free at its start; if none is, to the room that frees earliest, delayed so
// the booking keeps its length. The result word gives the room, the actual end, and the
// busiest room with its booking count. Per-room free times and counts live in two small
// RAMs that one compare path walks one entry per cycle: once over the active rooms to pick
// a room, then after the write step once more to find the busiest room. s_tready is high
// only between bookings. Reset clears all rooms at once through per-room valid bits, so
// no clearing pass is needed. Write rooms_in_use only while the block is idle;
// 0 acts as 1 and values above MAX_ROOMS act as MAX_ROOMS.
module earliest_free_room_allocator #(
    parameter int MAX_ROOMS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [efra_pkg::CFG_W-1:0]    cfg_wdata,     // rooms_in_use
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [efra_pkg::S_DATA_W-1:0] s_tdata,       // start_time, end_time
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // assigned_room, actual_end, busiest_room, busiest_count
    output logic [efra_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int CNT_W = $clog2(MAX_ROOMS + 1);
    localparam int IT_W  = efra_pkg::IN_TIME_W;
    localparam int T_W   = efra_pkg::TIME_W;
    localparam int C_W   = efra_pkg::COUNT_W;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN_FREE = 3'd1;
    localparam logic [2:0] ST_WRITE     = 3'd2;
    localparam logic [2:0] ST_SCAN_BUSY = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    // control state
    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             issue_reg, issue_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic                         found_reg, found_next;
    logic [MAX_ROOMS-1:0]         valid_reg, valid_next;
    logic [efra_pkg::CFG_W-1:0]   cfg_reg, cfg_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    // payload
    logic [IT_W-1:0]              start_reg, start_next;
    logic [IT_W-1:0]              len_reg, len_next;
    logic [IDX_W-1:0]             rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]             found_room_reg, found_room_next;
    efra_pkg::count_t             found_cnt_reg, found_cnt_next;
    efra_pkg::time_t              min_reg, min_next;
    logic [IDX_W-1:0]             min_room_reg, min_room_next;
    efra_pkg::count_t             min_cnt_reg, min_cnt_next;
    logic [IDX_W-1:0]             best_room_reg, best_room_next;
    efra_pkg::count_t             best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0]             room_reg, room_next;
    efra_pkg::time_t              finish_reg, finish_next;
    logic [efra_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [CNT_W-1:0]             active_n;
    efra_pkg::time_t              free_q, free_val;
    efra_pkg::count_t             cnt_q, cnt_val;
    logic                         entry_valid;
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    efra_pkg::time_t              ram_wfree;
    efra_pkg::count_t             ram_wcnt;
    logic [IDX_W-1:0]             pick_room;
    efra_pkg::count_t             pick_cnt;
    efra_pkg::time_t              pick_base;
    logic [T_W:0]                 pick_sum;
    efra_pkg::time_t              pick_finish;
    logic [IT_W-1:0]              in_start, in_end;

    assign in_start = s_tdata[IT_W-1:0];
    assign in_end   = s_tdata[2*IT_W-1:IT_W];

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if (32'(cfg_reg) > MAX_ROOMS)
        begin
            active_n = CNT_W'(MAX_ROOMS);
        end
        else
        begin
            active_n = CNT_W'(cfg_reg);
        end
    end

    // never-written rooms read as zero
    assign entry_valid = valid_reg[rd_idx_reg];
    assign free_val    = entry_valid ? free_q : '0;
    assign cnt_val     = entry_valid ? cnt_q : '0;

    // room choice and end time for the write step
    assign pick_room   = found_reg ? found_room_reg : min_room_reg;
    assign pick_cnt    = found_reg ? found_cnt_reg : min_cnt_reg;
    assign pick_base   = found_reg ? T_W'(start_reg) : min_reg;
    assign pick_sum    = {1'b0, pick_base} + (T_W + 1)'(len_reg);
    assign pick_finish = pick_sum[T_W] ? efra_pkg::TIME_MAX : pick_sum[T_W-1:0];

    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_waddr = pick_room;
    assign ram_wfree = pick_finish;
    assign ram_wcnt  = (pick_cnt == efra_pkg::COUNT_MAX) ? pick_cnt : pick_cnt + C_W'(1);

    efra_ram #(
        .WIDTH (T_W),
        .DEPTH (MAX_ROOMS)
    ) u_free_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wfree),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (free_q)
    );

    efra_ram #(
        .WIDTH (C_W),
        .DEPTH (MAX_ROOMS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wcnt),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (cnt_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        rd_valid_next   = 1'b0;
        found_next      = found_reg;
        valid_next      = valid_reg;
        cfg_next        = cfg_we ? cfg_wdata : cfg_reg;
        m_tvalid_next   = m_tvalid_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        rd_idx_next     = issue_reg[IDX_W-1:0];
        found_room_next = found_room_reg;
        found_cnt_next  = found_cnt_reg;
        min_next        = min_reg;
        min_room_next   = min_room_reg;
        min_cnt_next    = min_cnt_reg;
        best_room_next  = best_room_reg;
        best_cnt_next   = best_cnt_reg;
        room_next       = room_reg;
        finish_next     = finish_reg;
        m_tdata_next    = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // walk the rooms one address per cycle; read data returns in the next cycle
        if ((state_reg == ST_SCAN_FREE || state_reg == ST_SCAN_BUSY) && issue_reg != active_n)
        begin
            issue_next    = issue_reg + CNT_W'(1);
            rd_valid_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    start_next = in_start;
                    len_next   = (in_end > in_start) ? in_end - in_start : '0;
                    issue_next = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN_FREE;
                end
            end
            ST_SCAN_FREE:
            begin
                if (rd_valid_reg)
                begin
                    if (!found_reg && free_val <= T_W'(start_reg))
                    begin
                        found_next      = 1'b1;
                        found_room_next = rd_idx_reg;
                        found_cnt_next  = cnt_val;
                    end
                    if (rd_idx_reg == '0 || free_val < min_reg)
                    begin
                        min_next      = free_val;
                        min_room_next = rd_idx_reg;
                        min_cnt_next  = cnt_val;
                    end
                    if (issue_reg == active_n)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                valid_next[pick_room] = 1'b1;
                room_next             = pick_room;
                finish_next           = pick_finish;
                issue_next            = '0;
                state_next            = ST_SCAN_BUSY;
            end
            ST_SCAN_BUSY:
            begin
                if (rd_valid_reg)
                begin
                    if (rd_idx_reg == '0 || cnt_val > best_cnt_reg)
                    begin
                        best_cnt_next  = cnt_val;
                        best_room_next = rd_idx_reg;
                    end
                    if (issue_reg == active_n)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {best_cnt_reg, efra_pkg::ROOM_W'(best_room_reg),
                                     finish_reg, efra_pkg::ROOM_W'(room_reg)};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            valid_reg    <= '0;
            cfg_reg      <= efra_pkg::CFG_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            valid_reg    <= valid_next;
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        len_reg        <= len_next;
        rd_idx_reg     <= rd_idx_next;
        found_room_reg <= found_room_next;
        found_cnt_reg  <= found_cnt_next;
        min_reg        <= min_next;
        min_room_reg   <= min_room_next;
        min_cnt_reg    <= min_cnt_next;
        best_room_reg  <= best_room_next;
        best_cnt_reg   <= best_cnt_next;
        room_reg       <= room_next;
        finish_reg     <= finish_next;
        m_tdata_reg    <= m_tdata_next;
    end

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_FREE || state_reg == ST_SCAN_BUSY) |-> (issue_reg <= active_n))
        else $error("room walk ran past the active room count");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_SCAN_FREE || state_reg == ST_SCAN_BUSY))
        else $error("RAM read data returned outside a room walk");

    a_room_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> valid_reg[room_reg])
        else $error("written room not marked valid");

    a_end_not_early: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (pick_finish >= T_W'(start_reg)))
        else $error("booking end falls before its start");

endmodule

>>> tb/sv/earliest_free_room_allocator_checker.sv
`timescale 1ns / 1ps
module earliest_free_room_allocator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [efra_pkg::CFG_W-1:0]    cfg_wdata,     // rooms_in_use
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [efra_pkg::S_DATA_W-1:0] s_tdata,       // start_time, end_time
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // assigned_room, actual_end, busiest_room, busiest_count
    input  logic [efra_pkg::M_DATA_W-1:0] m_tdata,
    output int                            mismatch_count,
    output int                            results_pending
);

    localparam int ROOMS = 16;

    // first member lands in the top bits, so this matches m_tdata directly
    typedef struct packed {
        efra_pkg::count_t              busiest_count;
        logic [efra_pkg::ROOM_W-1:0]   busiest_room;
        efra_pkg::time_t               actual_end;
        logic [efra_pkg::ROOM_W-1:0]   assigned_room;
    } booking_result_t;

    logic [efra_pkg::CFG_W-1:0]  rooms_cfg;
    efra_pkg::time_t             free_at [ROOMS];
    efra_pkg::count_t            bookings [ROOMS];
    booking_result_t             booking_results_q [$];

    function automatic booking_result_t allocate_room(
        input logic [efra_pkg::IN_TIME_W-1:0] st,
        input logic [efra_pkg::IN_TIME_W-1:0] en);
        booking_result_t  res;
        efra_pkg::time_t  len;
        efra_pkg::time_t  when;
        int               n;
        int               room;
        int               i;
        bit               found;
        n = (rooms_cfg == 0) ? 1 : (rooms_cfg > ROOMS) ? ROOMS : int'(rooms_cfg);
        len = (en > st) ? efra_pkg::time_t'(en - st) : '0;
        found = 1'b0;
        room = 0;
        for (i = 0; i < n && !found; i++)
        begin
            if (free_at[i] <= efra_pkg::time_t'(st))
            begin
                room = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            res.actual_end = efra_pkg::time_t'(st) + len;
        end
        else
        begin
            // nothing free: take the earliest to free, lowest index on ties
            for (i = 1; i < n; i++)
            begin
                if (free_at[i] < free_at[room])
                    room = i;
            end
            when = free_at[room];
            res.actual_end = (len > efra_pkg::TIME_MAX - when) ? efra_pkg::TIME_MAX
                                                               : when + len;
        end
        free_at[room] = res.actual_end;
        if (bookings[room] != efra_pkg::COUNT_MAX)
            bookings[room] = bookings[room] + 1'b1;
        res.assigned_room = room[efra_pkg::ROOM_W-1:0];
        res.busiest_room = '0;
        res.busiest_count = bookings[0];
        for (i = 1; i < n; i++)
        begin
            if (bookings[i] > res.busiest_count)
            begin
                res.busiest_count = bookings[i];
                res.busiest_room = i[efra_pkg::ROOM_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        booking_result_t got;
        booking_result_t want;
        int              i;
        if (!rst_n)
        begin
            rooms_cfg = efra_pkg::CFG_RESET;
            for (i = 0; i < ROOMS; i++)
            begin
                free_at[i] = '0;
                bookings[i] = '0;
            end
            booking_results_q.delete();
            mismatch_count = 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_we)
                rooms_cfg = cfg_wdata;
            // compare before predicting: a word leaving now belongs to an older booking
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (booking_results_q.size() == 0)
                begin
                    report_mismatch("result word with none pending", 64'(got.actual_end), '0);
                end
                else
                begin
                    want = booking_results_q.pop_front();
                    if (got.assigned_room !== want.assigned_room)
                        report_mismatch("assigned_room", 64'(got.assigned_room),
                                        64'(want.assigned_room));
                    if (got.actual_end !== want.actual_end)
                        report_mismatch("actual_end", 64'(got.actual_end),
                                        64'(want.actual_end));
                    if (got.busiest_room !== want.busiest_room)
                        report_mismatch("busiest_room", 64'(got.busiest_room),
                                        64'(want.busiest_room));
                    if (got.busiest_count !== want.busiest_count)
                        report_mismatch("busiest_count", 64'(got.busiest_count),
                                        64'(want.busiest_count));
                end
            end
            if (s_tvalid && s_tready)
                booking_results_q.push_back(
                    allocate_room(s_tdata[efra_pkg::IN_TIME_W-1:0],
                                  s_tdata[efra_pkg::S_DATA_W-1:efra_pkg::IN_TIME_W]));
            results_pending <= booking_results_q.size();
        end
    end

endmodule

>>> tb/sv/earliest_free_room_allocator_tb.sv
`timescale 1ns / 1ps
module earliest_free_room_allocator_tb;

    localparam logic [efra_pkg::IN_TIME_W-1:0] T_MAX = '1;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [efra_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic [efra_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                            m_tready = 1'b0;
    wire                             s_tready;
    wire                             m_tvalid;
    wire [efra_pkg::M_DATA_W-1:0]    m_tdata;

    int                              sender_idle_pct = 0;
    int                              receiver_stall_pct = 0;
    int                              mismatch_count;
    int                              results_pending;

    int                              phase;
    int                              k;
    int                              r;
    int                              eff_rooms;
    logic [efra_pkg::IN_TIME_W-1:0]  back;
    logic [efra_pkg::CFG_W-1:0]      rooms;
    logic [efra_pkg::CFG_W-1:0]      room_plan [14];
    logic [efra_pkg::IN_TIME_W-1:0]  cur;
    logic [efra_pkg::IN_TIME_W-1:0]  st;
    logic [efra_pkg::IN_TIME_W-1:0]  en;

    earliest_free_room_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    earliest_free_room_allocator_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic logic [efra_pkg::IN_TIME_W-1:0] add_sat(
        input logic [efra_pkg::IN_TIME_W-1:0] a,
        input logic [efra_pkg::IN_TIME_W-1:0] b);
        logic [efra_pkg::IN_TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[efra_pkg::IN_TIME_W] ? T_MAX : s[efra_pkg::IN_TIME_W-1:0];
    endfunction

    task automatic send_booking(input logic [efra_pkg::IN_TIME_W-1:0] start_t,
                                input logic [efra_pkg::IN_TIME_W-1:0] end_t);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {end_t, start_t};
        do @(posedge clk); while (!s_tready);
    endtask

    // drain all pending results before touching the room count
    task automatic set_rooms(input logic [efra_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            1: begin sender_idle_pct = 46; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 46; end
            3: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        endcase
    endtask

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        room_plan = '{5'd16, 5'd1, 5'd0, 5'd4, 5'd16, 5'd16, 5'd31, 5'd2,
                      5'd8, 5'd16, 5'd3, 5'd16, 5'd5, 5'd12};
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero length, full range, end before start, ties, count folding
        set_idle_mode(0);
        send_booking('0, '0);
        send_booking('0, T_MAX);
        send_booking('0, 40'd5);
        send_booking(40'd3, 40'd2);
        send_booking(40'd5, 40'd9);
        set_rooms(5'd1);
        send_booking(40'd4, 40'd6);
        set_rooms(5'd0);
        send_booking(T_MAX, T_MAX);
        set_rooms(5'd31);
        send_booking(40'd2, 40'd1);
        send_booking(T_MAX, '0);
        set_rooms(5'd17);
        send_booking(40'd10, 40'd20);
        set_rooms(5'd2);
        send_booking(40'd6, 40'd7);
        send_booking(40'd7, 40'd8);
        send_booking(40'd8, 40'd9);
        set_rooms(5'd16);
        send_booking(40'd20, 40'd30);
        send_booking(40'd20, 40'd21);
        send_booking(40'd21, 40'd40);

        cur = 40'd100;
        for (phase = 0; phase < 14; phase++)
        begin
            rooms = (phase % 5 == 4) ? 5'($urandom_range(0, 31)) : room_plan[phase];
            set_rooms(rooms);
            set_idle_mode(phase % 4);
            eff_rooms = (rooms == 0) ? 1 : (rooms > 16) ? 16 : int'(rooms);
            // push the clock far ahead late in the run so the high time bits toggle
            if (phase >= 12)
                cur = T_MAX - (40'd1 << 30);
            else
                cur = add_sat(cur, 40'($urandom_range(0, 1 << 30)));
            for (k = 0; k < 100; k++)
            begin
                r = $urandom_range(99);
                if (r < 10)
                begin
                    // step back in time; half of these end at or before the start
                    back = 40'($urandom_range(0, 1000));
                    st = (cur > back) ? cur - back : '0;
                    if (r < 5)
                        en = (st > back) ? st - back : '0;
                    else
                        en = add_sat(st, 40'($urandom_range(0, 50)));
                end
                else
                begin
                    cur = add_sat(cur, 40'($urandom_range(0, 12)));
                    st = cur;
                    if (r < 14)
                        en = add_sat(st, 40'($urandom_range(0, 1 << 20)));
                    else
                        en = add_sat(st, 40'($urandom_range(0, 24 * eff_rooms)));
                end
                send_booking(st, en);
            end
        end

        // pile long bookings on one room until the end time saturates
        set_rooms(5'd1);
        set_idle_mode(3);
        repeat (300) send_booking('0, T_MAX);

        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
